// ===== rtl/braille_circle_raster_diff_engine_macros.svh =====
// Assertion macros used by the checker file of the Braille raster engine.
`ifndef BRAILLE_CIRCLE_RASTER_DIFF_ENGINE_MACROS_SVH
`define BRAILLE_CIRCLE_RASTER_DIFF_ENGINE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define BCRDE_AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, evaluated during reset too.
`define BCRDE_AST_NXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/bcrde_pkg.sv =====
// Shared codes, table lookups and glyph encoding of the Braille raster engine.
package bcrde_pkg;

    // command codes
    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_CIRCLE  = 2'd1;
    localparam logic [1:0] ACT_PRESENT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_COLS = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;

    // result item kinds
    localparam logic KIND_MOVE  = 1'b0;
    localparam logic KIND_GLYPH = 1'b1;

    localparam logic [7:0] UTF8_LEAD = 8'hE2;
    localparam logic [7:0] UTF8_MID  = 8'hA0;
    localparam logic [7:0] UTF8_CONT = 8'h80;
    localparam logic [7:0] UTF8_MASK = 8'h3F;

    // Braille dot numbering: left column 0,1,2,6 and right column 3,4,5,7
    function automatic logic [2:0] dot_bit(input logic in_col, input logic [1:0] in_row);
        logic [2:0] b;
        case ({in_col, in_row})
            3'b000:  b = 3'd0;
            3'b001:  b = 3'd1;
            3'b010:  b = 3'd2;
            3'b011:  b = 3'd6;
            3'b100:  b = 3'd3;
            3'b101:  b = 3'd4;
            3'b110:  b = 3'd5;
            default: b = 3'd7;
        endcase
        return b;
    endfunction

    // three UTF-8 bytes of the pattern's code point, packed high to low
    function automatic logic [23:0] glyph(input logic [7:0] p);
        return {UTF8_LEAD, UTF8_MID | {6'd0, p[7:6]}, UTF8_CONT | (p & UTF8_MASK)};
    endfunction

endpackage

// ===== rtl/braille_circle_raster_diff_engine.sv =====
// Braille raster engine: two cell stores, iterative circle fill, row diff presenter.
// Circle: one shared squarer squares the radius, then dx and dy per dot; a cell is
// written after eight dots. Present: both stores are read per cell and compared; a
// run start adds a glyph beat. Clear zeroes the front store, one cell written per cycle;
// items are never stalled. Reset (synchronous, active low) starts a pass zeroing both
// stores; busy stays high until it ends. Configuration writes are taken only while idle.
module braille_circle_raster_diff_engine #(
    parameter int COLS = 32,
    parameter int ROWS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_action,
    input  logic signed [15:0] i_center_x,
    input  logic signed [15:0] i_center_y,
    input  logic signed [15:0] i_radius,
    input  logic [3:0]  i_row_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    output logic        o_valid,
    output logic        o_kind,
    output logic [4:0]  o_screen_row,
    output logic [5:0]  o_screen_col,
    output logic [7:0]  o_dot_pattern,
    output logic [23:0] o_glyph_utf8,
    output logic        o_last
);

    localparam int DEPTH  = COLS * ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = $clog2(COLS + 1);
    localparam int RW     = $clog2(ROWS + 1);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_SWEEP = 10'b00_0000_0010,
        ST_C_R2  = 10'b00_0000_0100,
        ST_C_RD  = 10'b00_0000_1000,
        ST_C_MA  = 10'b00_0001_0000,
        ST_C_MB  = 10'b00_0010_0000,
        ST_C_WR  = 10'b00_0100_0000,
        ST_P_RD  = 10'b00_1000_0000,
        ST_P_CMP = 10'b01_0000_0000,
        ST_P_END = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    // cell stores
    logic [7:0] r_front [DEPTH];
    logic [7:0] r_back  [DEPTH];
    logic [7:0] r_front_q, r_back_q;

    logic [5:0] r_cols_cfg;
    logic [4:0] r_rows_cfg;

    logic [ADDR_W-1:0] r_sweep, n_sweep;
    logic              r_clr_back, n_clr_back;
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic [2:0]        r_dot, n_dot;
    logic              r_run, n_run;
    logic              r_glyph_due, n_glyph_due;

    logic signed [15:0] r_cx, r_cy, r_rad;
    logic [33:0]        r_r2, n_r2;
    logic [33:0]        r_sq, n_sq;
    logic [7:0]         r_acc, n_acc;

    // pending result item, held until the next one or the end of the row
    logic        r_pend_v, n_pend_v;
    logic        r_pend_kind, n_pend_kind;
    logic [5:0]  r_pend_col, n_pend_col;
    logic [7:0]  r_pend_pat, n_pend_pat;

    logic        r_ovalid, n_ovalid;
    logic        r_okind, n_okind;
    logic [5:0]  r_ocol, n_ocol;
    logic [7:0]  r_opat, n_opat;
    logic        r_olast, n_olast;
    logic [4:0]  r_orow, n_orow;

    logic [CW-1:0] w_cols_eff;
    logic [RW-1:0] w_rows_eff;
    logic [ADDR_W-1:0] w_addr;
    logic          w_accept;

    // shared squarer
    logic signed [16:0] w_mop;
    logic signed [33:0] w_prod;
    logic signed [16:0] w_dx, w_dy;
    logic [CW:0]        w_px;
    logic [RW+1:0]      w_py;

    // memory port controls
    logic              w_f_we, w_b_we, w_f_re, w_b_re;
    logic [ADDR_W-1:0] w_waddr;
    logic [7:0]        w_f_wd;

    // push of one new result item
    logic       w_push;
    logic       w_push_kind;
    logic [5:0] w_push_col;
    logic [7:0] w_push_pat;
    logic       w_col_end, w_row_end;

    assign w_accept   = i_start && (r_state == ST_IDLE);
    assign o_busy     = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);

    assign w_cols_eff = (int'(r_cols_cfg) > COLS) ? CW'(COLS) : CW'(r_cols_cfg);
    assign w_rows_eff = (int'(r_rows_cfg) > ROWS) ? RW'(ROWS) : RW'(r_rows_cfg);
    assign w_addr = ADDR_W'(r_row) * ADDR_W'(COLS) + ADDR_W'(r_col);

    // dot offsets from the centre, 4 fraction bits
    assign w_px = {r_col, r_dot[0]};
    assign w_py = {r_row, r_dot[2:1]};
    assign w_dx = $signed(17'({w_px, 4'b0000})) - $signed({r_cx[15], r_cx});
    assign w_dy = $signed(17'({w_py, 4'b0000})) - $signed({r_cy[15], r_cy});

    always_comb begin
        case (r_state)
            ST_C_R2: w_mop = {r_rad[15], r_rad};
            ST_C_MA: w_mop = w_dx;
            default: w_mop = w_dy;
        endcase
    end
    assign w_prod = w_mop * w_mop;

    assign w_col_end = (r_col == w_cols_eff - CW'(1));
    assign w_row_end = (r_row == w_rows_eff - RW'(1));

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_clr_back  = r_clr_back;
        n_col       = r_col;
        n_row       = r_row;
        n_dot       = r_dot;
        n_run       = r_run;
        n_glyph_due = r_glyph_due;
        n_r2        = r_r2;
        n_sq        = r_sq;
        n_acc       = r_acc;
        w_f_we      = 1'b0;
        w_b_we      = 1'b0;
        w_f_re      = 1'b0;
        w_b_re      = 1'b0;
        w_waddr     = w_addr;
        w_f_wd      = r_front_q | r_acc;
        w_push      = 1'b0;
        w_push_kind = bcrde_pkg::KIND_GLYPH;
        w_push_col  = 6'(r_col) + 6'd1;
        w_push_pat  = r_front_q;
        case (r_state)
            ST_IDLE: begin
                n_col = '0;
                n_row = '0;
                n_dot = '0;
                n_run = 1'b0;
                n_glyph_due = 1'b0;
                if (w_accept) begin
                    case (i_action)
                        bcrde_pkg::ACT_CLEAR: begin
                            n_sweep    = '0;
                            n_clr_back = 1'b0;
                            n_state    = ST_SWEEP;
                        end
                        bcrde_pkg::ACT_CIRCLE: begin
                            if (!i_radius[15] && (i_radius != 16'sd0) &&
                                (w_cols_eff != '0) && (w_rows_eff != '0)) begin
                                n_state = ST_C_R2;
                            end
                        end
                        bcrde_pkg::ACT_PRESENT: begin
                            n_row = RW'(i_row_index);
                            if ((RW'(i_row_index) < w_rows_eff) && (w_cols_eff != '0)) begin
                                n_state = ST_P_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SWEEP: begin
                w_waddr = r_sweep;
                w_f_wd  = 8'd0;
                w_f_we  = 1'b1;
                w_b_we  = r_clr_back;
                n_sweep = r_sweep + ADDR_W'(1);
                if (r_sweep == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_C_R2: begin
                n_r2    = 34'(w_prod);
                n_state = ST_C_RD;
            end
            ST_C_RD: begin
                w_f_re  = 1'b1;
                n_acc   = 8'd0;
                n_dot   = 3'd0;
                n_state = ST_C_MA;
            end
            ST_C_MA: begin
                n_sq    = 34'(w_prod);
                n_state = ST_C_MB;
            end
            ST_C_MB: begin
                // inside test for one dot
                if ({1'b0, r_sq} + {1'b0, 34'(w_prod)} <= {1'b0, r_r2}) begin
                    n_acc = r_acc | (8'd1 << bcrde_pkg::dot_bit(r_dot[0], r_dot[2:1]));
                end
                n_dot   = r_dot + 3'd1;
                n_state = (r_dot == 3'd7) ? ST_C_WR : ST_C_MA;
            end
            ST_C_WR: begin
                w_f_we = 1'b1;
                if (w_col_end) begin
                    n_col = '0;
                    n_row = r_row + RW'(1);
                    n_state = w_row_end ? ST_IDLE : ST_C_RD;
                end else begin
                    n_col   = r_col + CW'(1);
                    n_state = ST_C_RD;
                end
            end
            ST_P_RD: begin
                w_f_re  = 1'b1;
                w_b_re  = 1'b1;
                n_state = ST_P_CMP;
            end
            ST_P_CMP: begin
                if (r_glyph_due) begin
                    // second beat of a run start: glyph of the same cell
                    w_push      = 1'b1;
                    n_glyph_due = 1'b0;
                end else begin
                    w_b_we = 1'b1;
                    w_f_wd = r_front_q;
                    if (r_front_q != r_back_q) begin
                        w_push = 1'b1;
                        if (!r_run) begin
                            w_push_kind = bcrde_pkg::KIND_MOVE;
                            w_push_pat  = 8'd0;
                            n_run       = 1'b1;
                            n_glyph_due = 1'b1;
                        end
                    end else begin
                        n_run = 1'b0;
                    end
                end
                if (!n_glyph_due) begin
                    n_col   = r_col + CW'(1);
                    n_state = w_col_end ? ST_P_END : ST_P_RD;
                end
            end
            ST_P_END: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // pending item and output register
    always_comb begin
        n_pend_v    = r_pend_v;
        n_pend_kind = r_pend_kind;
        n_pend_col  = r_pend_col;
        n_pend_pat  = r_pend_pat;
        n_okind     = r_pend_kind;
        n_ocol      = r_pend_col;
        n_opat      = r_pend_pat;
        n_orow      = 5'(r_row) + 5'd1;
        n_ovalid    = 1'b0;
        n_olast     = 1'b0;
        if (w_push) begin
            n_ovalid    = r_pend_v;
            n_pend_v    = 1'b1;
            n_pend_kind = w_push_kind;
            n_pend_col  = w_push_col;
            n_pend_pat  = w_push_pat;
        end else if (r_state == ST_P_END) begin
            n_ovalid = r_pend_v;
            n_olast  = 1'b1;
            n_pend_v = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep     <= '0;
            r_clr_back  <= 1'b1;
            r_cols_cfg  <= 6'd32;
            r_rows_cfg  <= 5'd16;
            r_ovalid    <= 1'b0;
            r_pend_v    <= 1'b0;
            r_run       <= 1'b0;
            r_glyph_due <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_clr_back  <= n_clr_back;
            r_ovalid    <= n_ovalid;
            r_pend_v    <= n_pend_v;
            r_run       <= n_run;
            r_glyph_due <= n_glyph_due;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bcrde_pkg::CFG_COLS: r_cols_cfg <= i_cfg_data;
                    bcrde_pkg::CFG_ROWS: r_rows_cfg <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_col       <= n_col;
        r_row       <= n_row;
        r_dot       <= n_dot;
        r_r2        <= n_r2;
        r_sq        <= n_sq;
        r_acc       <= n_acc;
        r_pend_kind <= n_pend_kind;
        r_pend_col  <= n_pend_col;
        r_pend_pat  <= n_pend_pat;
        r_okind     <= n_okind;
        r_ocol      <= n_ocol;
        r_opat      <= n_opat;
        r_olast     <= n_olast;
        r_orow      <= n_orow;
        if (w_accept) begin
            r_cx  <= i_center_x;
            r_cy  <= i_center_y;
            r_rad <= i_radius;
        end
    end

    // front store
    always_ff @(posedge i_clk) begin
        if (w_f_we) begin
            r_front[w_waddr] <= w_f_wd;
        end
        if (w_f_re) begin
            r_front_q <= r_front[w_addr];
        end
    end

    // back store
    always_ff @(posedge i_clk) begin
        if (w_b_we) begin
            r_back[w_waddr] <= w_f_wd;
        end
        if (w_b_re) begin
            r_back_q <= r_back[w_addr];
        end
    end

    assign o_valid       = r_ovalid;
    assign o_kind        = r_okind;
    assign o_screen_row  = r_orow;
    assign o_screen_col  = r_ocol;
    assign o_dot_pattern = r_opat;
    assign o_glyph_utf8  = (r_okind == bcrde_pkg::KIND_GLYPH) ?
                           bcrde_pkg::glyph(r_opat) : 24'd0;
    assign o_last        = r_olast;

endmodule

// ===== rtl/bcrde_checker.sv =====
// Port-level checker of the Braille raster engine and its bind.
`include "braille_circle_raster_diff_engine_macros.svh"

module bcrde_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [1:0]  i_action,
    input logic        o_valid,
    input logic        o_kind,
    input logic [7:0]  o_dot_pattern,
    input logic [23:0] o_glyph_utf8,
    input logic        o_last
);

    // a cursor move carries no pattern and no glyph bytes
    `BCRDE_AST_IMP(a_move_empty, i_clk, i_rst_n, o_valid && (o_kind == bcrde_pkg::KIND_MOVE), (o_dot_pattern == 8'd0) && (o_glyph_utf8 == 24'd0))

    // a glyph beat starts with the Braille lead byte
    `BCRDE_AST_IMP(a_glyph_lead, i_clk, i_rst_n, o_valid && (o_kind == bcrde_pkg::KIND_GLYPH), o_glyph_utf8[23:16] == bcrde_pkg::UTF8_LEAD)

    // nothing follows the final beat of a present in the next cycle
    `BCRDE_AST_NXT(a_last_gap, i_clk, i_rst_n && o_valid && o_last, !o_valid)

    // reset starts the clearing pass
    `BCRDE_AST_NXT(a_reset_sweep, i_clk, !i_rst_n, o_busy && !o_valid)

    // a clear command that is taken makes the block busy
    `BCRDE_AST_NXT(a_clear_busy, i_clk, i_rst_n && i_start && !o_busy && (i_action == bcrde_pkg::ACT_CLEAR), o_busy)

endmodule

bind braille_circle_raster_diff_engine bcrde_checker u_bcrde_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .i_action      (i_action),
    .o_valid       (o_valid),
    .o_kind        (o_kind),
    .o_dot_pattern (o_dot_pattern),
    .o_glyph_utf8  (o_glyph_utf8),
    .o_last        (o_last)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the Braille circle raster engine with row diff presenter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NC = 32;
    localparam int NR = 16;
    localparam int STALL_LIMIT = 40000;

    // codes the block ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [1:0]  i_action = bcrde_pkg::ACT_CLEAR;
    logic signed [15:0] i_center_x = '0;
    logic signed [15:0] i_center_y = '0;
    logic signed [15:0] i_radius = '0;
    logic [3:0]  i_row_index = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = bcrde_pkg::CFG_COLS;
    logic [5:0]  i_cfg_data = '0;
    logic        o_valid;
    logic        o_kind;
    logic [4:0]  o_screen_row;
    logic [5:0]  o_screen_col;
    logic [7:0]  o_dot_pattern;
    logic [23:0] o_glyph_utf8;
    logic        o_last;

    braille_circle_raster_diff_engine #(.COLS(NC), .ROWS(NR)) dut (.*);

    always #10 i_clk = ~i_clk;

    typedef struct packed {
        logic        kind;
        logic [4:0]  row;
        logic [5:0]  col;
        logic [7:0]  pat;
        logic [23:0] utf;
        logic        last;
    } t_screen_item;

    typedef struct packed {
        logic [1:0]  action;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] rad;
        logic [3:0]  row;
    } t_command;

    // predictor state
    logic [7:0] front_cells [NC*NR];
    logic [7:0] back_cells [NC*NR];
    logic [5:0] cols_reg;
    logic [4:0] rows_reg;
    t_screen_item pending_items [$];

    int mismatches = 0;
    int idle_cycles = 0;
    int items_seen = 0;
    int commands_sent = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic int cols_eff();
        return (cols_reg > NC) ? NC : int'(cols_reg);
    endfunction

    function automatic int rows_eff();
        return (rows_reg > NR) ? NR : int'(rows_reg);
    endfunction

    function automatic logic [7:0] braille_bit(input int px, input int py);
        logic [2:0] b;
        case ({px[0], py[1:0]})
            3'b000: b = 3'd0;
            3'b001: b = 3'd1;
            3'b010: b = 3'd2;
            3'b011: b = 3'd6;
            3'b100: b = 3'd3;
            3'b101: b = 3'd4;
            3'b110: b = 3'd5;
            default: b = 3'd7;
        endcase
        return 8'd1 << b;
    endfunction

    function automatic t_screen_item make_item(input logic kind, input int r, input int c,
                                               input logic [7:0] p);
        t_screen_item it;
        it.kind = kind;
        it.row = 5'(r + 1);
        it.col = 6'(c + 1);
        it.pat = kind ? p : 8'd0;
        it.utf = kind ? {8'hE2, 8'hA0 | {6'd0, p[7:6]}, 8'h80 | {2'b0, p[5:0]}} : 24'd0;
        it.last = 1'b0;
        return it;
    endfunction

    // applies one command to the model and queues the screen items it yields
    task automatic predict_command(input t_command cmd);
        longint dx, dy, r2;
        int n0, run0, xl, yl;
        logic in_run;
        n0 = pending_items.size();
        case (cmd.action)
            bcrde_pkg::ACT_CLEAR: foreach (front_cells[i]) front_cells[i] = 8'd0;
            bcrde_pkg::ACT_CIRCLE: if (cmd.rad > 0) begin
                r2 = longint'(cmd.rad) * longint'(cmd.rad);
                xl = 2 * cols_eff();
                yl = 4 * rows_eff();
                for (int py = 0; py < yl; py++) begin
                    dy = longint'(py) * 16 - longint'(cmd.cy);
                    for (int px = 0; px < xl; px++) begin
                        dx = longint'(px) * 16 - longint'(cmd.cx);
                        if (dx * dx + dy * dy <= r2)
                            front_cells[(py >> 2) * NC + (px >> 1)] |= braille_bit(px, py);
                    end
                end
            end
            bcrde_pkg::ACT_PRESENT: if (int'(cmd.row) < rows_eff()) begin
                in_run = 1'b0;
                run0 = 0;
                for (int c = 0; c <= cols_eff(); c++) begin
                    if (c < cols_eff() &&
                        front_cells[cmd.row * NC + c] != back_cells[cmd.row * NC + c]) begin
                        if (!in_run) begin
                            in_run = 1'b1;
                            run0 = c;
                        end
                    end else if (in_run) begin
                        pending_items.push_back(make_item(bcrde_pkg::KIND_MOVE, cmd.row,
                                                          run0, 8'd0));
                        for (int k = run0; k < c; k++)
                            pending_items.push_back(make_item(bcrde_pkg::KIND_GLYPH, cmd.row,
                                                              k, front_cells[cmd.row * NC + k]));
                        in_run = 1'b0;
                    end
                end
                for (int c = 0; c < cols_eff(); c++)
                    back_cells[cmd.row * NC + c] = front_cells[cmd.row * NC + c];
                if (pending_items.size() > n0)
                    pending_items[pending_items.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    // check each result beat against the oldest expected item
    always @(posedge i_clk) begin
        t_screen_item want;
        if (i_rst_n && o_valid) begin
            items_seen++;
            if (pending_items.size() == 0) begin
                report("unexpected item col", o_screen_col, 0);
            end else begin
                want = pending_items.pop_front();
                if (o_kind !== want.kind) report("kind", o_kind, want.kind);
                if (o_screen_row !== want.row) report("screen_row", o_screen_row, want.row);
                if (o_screen_col !== want.col) report("screen_col", o_screen_col, want.col);
                if (o_dot_pattern !== want.pat) report("dot_pattern", o_dot_pattern, want.pat);
                if (o_glyph_utf8 !== want.utf) report("glyph_utf8", o_glyph_utf8, want.utf);
                if (o_last !== want.last) report("last", o_last, want.last);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("watchdog expired");
            $display("Mismatches found");
            $finish;
        end
    end

    // holds start until a falling-edge look shows the block idle, so the next edge takes it
    task automatic send_command(input t_command cmd, input int gap);
        logic taken;
        repeat (gap + 1) @(posedge i_clk);
        i_action <= cmd.action;
        i_center_x <= cmd.cx;
        i_center_y <= cmd.cy;
        i_radius <= cmd.rad;
        i_row_index <= cmd.row;
        i_start <= 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_busy;
            @(posedge i_clk);
        end
        predict_command(cmd);
        commands_sent++;
        i_start <= 1'b0;
    endtask

    // waits for the queue to drain, then lets the block settle
    task automatic drain();
        while (pending_items.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        drain();
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == bcrde_pkg::CFG_COLS) cols_reg = val;
        else if (idx == bcrde_pkg::CFG_ROWS) rows_reg = val[4:0];
    endtask

    function automatic t_command cmd_of(input logic [1:0] a, input int x, input int y,
                                        input int r, input int row);
        t_command c;
        c.action = a;
        c.cx = 16'(x);
        c.cy = 16'(y);
        c.rad = 16'(r);
        c.row = 4'(row);
        return c;
    endfunction

    function automatic t_command random_command();
        t_command c;
        int roll;
        roll = $urandom_range(0, 99);
        c.cx = 16'($urandom_range(0, 1100) - 60);
        c.cy = 16'($urandom_range(0, 1100) - 60);
        c.rad = 16'($urandom_range(0, 200));
        c.row = 4'($urandom);
        if (roll < 4) c.action = bcrde_pkg::ACT_CLEAR;
        else if (roll < 36) c.action = bcrde_pkg::ACT_CIRCLE;
        else if (roll < 96) c.action = bcrde_pkg::ACT_PRESENT;
        else begin
            c.action = ACT_UNUSED;
            c.cx = 16'($urandom);
            c.cy = 16'($urandom);
            c.rad = 16'($urandom);
        end
        if (roll % 9 == 0 && c.action == bcrde_pkg::ACT_CIRCLE) begin
            c.cx = 16'($urandom);
            c.cy = 16'($urandom);
            c.rad = 16'($urandom);
        end
        return c;
    endfunction

    t_command directed [$];
    t_screen_item row0_glyph;

    initial begin
        int burst;
        foreach (front_cells[i]) begin
            front_cells[i] = 8'd0;
            back_cells[i] = 8'd0;
        end
        cols_reg = 6'd32;
        rows_reg = 5'd16;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: extremes, every action, special cases
        directed = '{
            cmd_of(bcrde_pkg::ACT_PRESENT, 0, 0, 0, 0),            // unchanged row after reset
            cmd_of(bcrde_pkg::ACT_CIRCLE, 0, 0, 8, 0),             // one dot at origin
            cmd_of(bcrde_pkg::ACT_PRESENT, 0, 0, 0, 0),
            cmd_of(bcrde_pkg::ACT_CIRCLE, 100, 100, 0, 0),         // zero radius
            cmd_of(bcrde_pkg::ACT_CIRCLE, 100, 100, -32768, 0),    // negative radius
            cmd_of(bcrde_pkg::ACT_CIRCLE, -32768, -32768, 32767, 0),
            cmd_of(bcrde_pkg::ACT_PRESENT, 0, 0, 0, 15),
            cmd_of(bcrde_pkg::ACT_CIRCLE, 32767, 32767, 32767, 0),
            cmd_of(bcrde_pkg::ACT_CIRCLE, 496, 248, 80, 0),
            cmd_of(bcrde_pkg::ACT_PRESENT, 0, 0, 0, 15),
            cmd_of(bcrde_pkg::ACT_PRESENT, 0, 0, 0, 7),
            cmd_of(ACT_UNUSED, -1, -1, -1, 15),                    // unused action
            cmd_of(bcrde_pkg::ACT_CLEAR, 0, 0, 0, 0),
            cmd_of(bcrde_pkg::ACT_PRESENT, 0, 0, 0, 7),
            cmd_of(bcrde_pkg::ACT_CIRCLE, 1008, 500, 40, 0),       // right edge clip
            cmd_of(bcrde_pkg::ACT_PRESENT, 0, 0, 0, 8),
            cmd_of(bcrde_pkg::ACT_PRESENT, 0, 0, 0, 8)
        };
        foreach (directed[i]) begin
            send_command(directed[i], $urandom_range(0, 2));
            // a single origin dot presents a move then the dot glyph at row 1 col 1
            if (i == 2) begin
                row0_glyph = pending_items[1];
                if (row0_glyph.utf != 24'hE2A081) report("origin glyph table", row0_glyph.utf,
                                                         24'hE2A081);
            end
        end

        // register extremes, including beyond-parameter and empty screens
        write_reg(bcrde_pkg::CFG_COLS, 6'd20);
        write_reg(bcrde_pkg::CFG_ROWS, 6'd10);
        write_reg(CFG_UNUSED, 6'h3F);
        send_command(cmd_of(bcrde_pkg::ACT_CIRCLE, 320, 160, 400, 0), 0);
        send_command(cmd_of(bcrde_pkg::ACT_PRESENT, 0, 0, 0, 9), 0);
        send_command(cmd_of(bcrde_pkg::ACT_PRESENT, 0, 0, 0, 10), 0);
        write_reg(bcrde_pkg::CFG_COLS, 6'd63);
        write_reg(bcrde_pkg::CFG_ROWS, 6'd31);
        send_command(cmd_of(bcrde_pkg::ACT_PRESENT, 0, 0, 0, 15), 0);
        write_reg(bcrde_pkg::CFG_COLS, 6'd0);
        send_command(cmd_of(bcrde_pkg::ACT_CIRCLE, 0, 0, 200, 0), 0);
        send_command(cmd_of(bcrde_pkg::ACT_PRESENT, 0, 0, 0, 0), 0);
        write_reg(bcrde_pkg::CFG_ROWS, 6'd0);
        send_command(cmd_of(bcrde_pkg::ACT_PRESENT, 0, 0, 0, 0), 0);

        // random phases with varying screen sizes, bursts and gaps
        for (int phase = 0; phase < 5; phase++) begin
            write_reg(bcrde_pkg::CFG_COLS, 6'($urandom_range(20, 32)));
            write_reg(bcrde_pkg::CFG_ROWS, 6'($urandom_range(10, 16)));
            for (int n = 0; n < 50; ) begin
                burst = $urandom_range(1, 8);
                for (int b = 0; b < burst && n < 50; b++, n++)
                    send_command(random_command(), (phase == 2) ? 0 : (b == 0 ?
                                 $urandom_range(0, 12) : $urandom_range(0, 1)));
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        $display("Run covered %0d commands and %0d screen items over several screen sizes.",
                 commands_sent, items_seen);
        if (mismatches == 0 && pending_items.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
